// ----- rtl/bilup_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image upscaler package
// Shared types, codes and the channel blend function.
// ----------------------------------------------------------------------------
package bilup_pkg;

  localparam int COORD_W   = 12;
  localparam int ADDR_W    = 17;
  localparam int COLOR_W   = 24;
  localparam int PIXEL_W   = 32;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 1'b1;

  localparam logic [7:0] ALPHA = 8'hFF;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] fx;
    logic [7:0] fy;
  } frac_t;

  // a + floor((b - a) * f / 256); the true result always fits in 8 bits.
  function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] f);
    logic signed [9:0]  diff;
    logic signed [18:0] prod;
    logic signed [18:0] shr;
    diff = $signed({2'b00, b}) - $signed({2'b00, a});
    prod = diff * $signed({1'b0, f});
    shr  = prod >>> 8;
    return a + shr[7:0];
  endfunction

endpackage

// ----- rtl/bilup_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mapping divider
// Two restoring division lanes, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module bilup_div #(
  parameter int QW  = 17,
  parameter int DW  = 12,
  parameter int SBW = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [bilup_pkg::COORD_W+QW-1:0] num_x,
  input  logic [bilup_pkg::COORD_W+QW-1:0] num_y,
  input  logic [DW-1:0]                  div_x,
  input  logic [DW-1:0]                  div_y,
  input  logic [SBW-1:0]                 side_in,
  output logic                           out_valid,
  output logic [QW-1:0]                  q_x,
  output logic [QW-1:0]                  q_y,
  output logic [SBW-1:0]                 side_out
);

  localparam int NW = bilup_pkg::COORD_W + QW;
  localparam int RW = DW + 1;

  typedef struct packed {
    logic [RW-1:0]  rx;
    logic [RW-1:0]  ry;
    logic [QW-1:0]  qx;
    logic [QW-1:0]  qy;
    logic [NW-1:0]  nx;
    logic [NW-1:0]  ny;
    logic [SBW-1:0] side;
  } stage_t;

  logic [QW-1:0] vld;
  stage_t        st [QW];
  stage_t        init;

  always_comb begin
    init.rx   = RW'(num_x[NW-1:QW]);
    init.ry   = RW'(num_y[NW-1:QW]);
    init.qx   = '0;
    init.qy   = '0;
    init.nx   = num_x;
    init.ny   = num_y;
    init.side = side_in;
  end

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    stage_t        p;
    stage_t        nxt;
    logic          pv;
    logic [RW-1:0] tx;
    logic [RW-1:0] ty;
    logic          bx;
    logic          by;

    if (k == 0) begin : g_first
      assign p  = init;
      assign pv = in_valid;
    end else begin : g_rest
      assign p  = st[k-1];
      assign pv = vld[k-1];
    end

    assign tx = {p.rx[RW-2:0], p.nx[QW-1-k]};
    assign ty = {p.ry[RW-2:0], p.ny[QW-1-k]};
    assign bx = (tx >= {1'b0, div_x});
    assign by = (ty >= {1'b0, div_y});

    always_comb begin
      nxt    = p;
      nxt.rx = bx ? (tx - {1'b0, div_x}) : tx;
      nxt.ry = by ? (ty - {1'b0, div_y}) : ty;
      nxt.qx = {p.qx[QW-2:0], bx};
      nxt.qy = {p.qy[QW-2:0], by};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign q_x       = st[QW-1].qx;
  assign q_y       = st[QW-1].qy;
  assign side_out  = st[QW-1].side;

endmodule

// ----- rtl/bilup_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source image bank
// One quarter of the source image, one write and one registered read port.
// ----------------------------------------------------------------------------
module bilup_bank #(
  parameter int DEPTH = 19200,
  parameter int AW    = 15
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [bilup_pkg::COLOR_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [bilup_pkg::COLOR_W-1:0] rdata
);

  logic [bilup_pkg::COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bilup_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear blend
// Horizontal blend of both rows, then vertical blend into the ARGB register.
// ----------------------------------------------------------------------------
module bilup_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  bilup_pkg::rgb_t               a,
  input  bilup_pkg::rgb_t               b,
  input  bilup_pkg::rgb_t               c,
  input  bilup_pkg::rgb_t               d,
  input  bilup_pkg::frac_t              frac,
  output logic                          out_valid,
  output logic [bilup_pkg::PIXEL_W-1:0] pixel
);

  logic            v1;
  bilup_pkg::rgb_t t0;
  bilup_pkg::rgb_t t1;
  logic [7:0]      fy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0.r  <= bilup_pkg::lerp(a.r, b.r, frac.fx);
      t0.g  <= bilup_pkg::lerp(a.g, b.g, frac.fx);
      t0.b  <= bilup_pkg::lerp(a.b, b.b, frac.fx);
      t1.r  <= bilup_pkg::lerp(c.r, d.r, frac.fx);
      t1.g  <= bilup_pkg::lerp(c.g, d.g, frac.fx);
      t1.b  <= bilup_pkg::lerp(c.b, d.b, frac.fx);
      fy1   <= frac.fy;
      pixel <= {bilup_pkg::ALPHA, bilup_pkg::lerp(t0.r, t1.r, fy1),
                bilup_pkg::lerp(t0.g, t1.g, fy1), bilup_pkg::lerp(t0.b, t1.b, fy1)};
    end
  end

endmodule

// ----- rtl/bilinear_image_upscaler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image upscaler core
// Source image store with a pipelined bilinear sampler.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock, pixel writes and sample requests
// alike, and returns one ARGB pixel for each sample. A sample passes the input,
// divider, map, bank address, bank read and blend registers to the output. QW
// is the width of the mapping quotient (17 for a 320 x 240 source): the division
// runs one quotient bit per stage. The source image lives in four banks split
// by column and row parity, so the four neighbors are read in the same cycle.
// Writes travel the same pipeline and reach the banks in order with samples.
// The whole pipeline holds while a result waits under out_stall.
module bilinear_image_upscaler_core #(
  parameter int SRC_WIDTH   = 320,
  parameter int SRC_HEIGHT  = 240,
  parameter int MAX_OUT_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bilup_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bilup_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [bilup_pkg::ADDR_W-1:0]      src_addr,
  input  logic [bilup_pkg::COLOR_W-1:0]     src_color,
  input  logic [bilup_pkg::COORD_W-1:0]     out_x,
  input  logic [bilup_pkg::COORD_W-1:0]     out_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bilup_pkg::PIXEL_W-1:0]     out_pixel
);

  localparam int KX    = (SRC_WIDTH - 1) * 256;
  localparam int KY    = (SRC_HEIGHT - 1) * 256;
  localparam int KMAX  = (KX > KY) ? KX : KY;
  localparam int QW    = $clog2(KMAX);
  localparam int NW    = bilup_pkg::COORD_W + QW;
  localparam int DW    = $clog2(MAX_OUT_DIM);
  localparam int XW    = $clog2(SRC_WIDTH);
  localparam int YW    = $clog2(SRC_HEIGHT);
  localparam int BW    = (SRC_WIDTH + 1) / 2;
  localparam int BD    = BW * ((SRC_HEIGHT + 1) / 2);
  localparam int BA    = $clog2(BD);
  localparam int RSH   = 18;
  localparam int RECIP = (1 << RSH) / SRC_WIDTH;
  localparam int NPIX  = SRC_WIDTH * SRC_HEIGHT;
  localparam int RW_W  = (320 < MAX_OUT_DIM) ? 320 : MAX_OUT_DIM;
  localparam int RW_H  = (240 < MAX_OUT_DIM) ? 240 : MAX_OUT_DIM;
  localparam int RST_DX = (RW_W > 1) ? RW_W - 1 : 1;
  localparam int RST_DY = (RW_H > 1) ? RW_H - 1 : 1;

  typedef struct packed {
    logic                          kind;
    logic [bilup_pkg::ADDR_W-1:0]  addr;
    logic [bilup_pkg::COLOR_W-1:0] color;
    logic                          cx;
    logic                          cy;
    logic [bilup_pkg::ADDR_W-1:0]  rowest;
  } side_t;

  localparam int SBW = $bits(side_t);

  logic          adv;
  logic [DW-1:0] div_x;
  logic [DW-1:0] div_y;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Configuration
  logic [31:0] cfg_sat;
  logic [DW-1:0] cfg_div;

  always_comb begin
    cfg_sat = (32'(cfg_data) > 32'(MAX_OUT_DIM)) ? 32'(MAX_OUT_DIM) : 32'(cfg_data);
    cfg_div = (cfg_sat > 32'd1) ? DW'(cfg_sat - 32'd1) : DW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_x <= DW'(RST_DX);
      div_y <= DW'(RST_DY);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bilup_pkg::REG_OUT_WIDTH:  div_x <= cfg_div;
        bilup_pkg::REG_OUT_HEIGHT: div_y <= cfg_div;
        default: ;
      endcase
    end
  end

  // Input stage
  logic          s0_valid;
  side_t         s0_side;
  logic [NW-1:0] s0_nx;
  logic [NW-1:0] s0_ny;
  logic [35:0]   rprod;

  assign rprod = 36'(src_addr) * 36'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side.kind   <= kind;
      s0_side.addr   <= src_addr;
      s0_side.color  <= src_color;
      s0_side.cx     <= (32'(out_x) >= 32'(div_x));
      s0_side.cy     <= (32'(out_y) >= 32'(div_y));
      s0_side.rowest <= rprod[RSH+bilup_pkg::ADDR_W-1:RSH];
      s0_nx          <= NW'(32'(out_x) * 32'(KX));
      s0_ny          <= NW'(32'(out_y) * 32'(KY));
    end
  end

  // Coordinate division
  logic          d_valid;
  logic [QW-1:0] d_qx;
  logic [QW-1:0] d_qy;
  logic [SBW-1:0] d_side_vec;
  side_t         d_side;

  bilup_div #(.QW(QW), .DW(DW), .SBW(SBW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s0_valid),
    .num_x    (s0_nx),
    .num_y    (s0_ny),
    .div_x    (div_x),
    .div_y    (div_y),
    .side_in  (s0_side),
    .out_valid(d_valid),
    .q_x      (d_qx),
    .q_y      (d_qy),
    .side_out (d_side_vec)
  );

  assign d_side = side_t'(d_side_vec);

  // Map stage
  logic                          m_valid;
  logic                          m_kind;
  logic                          m_ok;
  logic [XW-1:0]                 m_xi;
  logic [YW-1:0]                 m_yi;
  logic [XW-1:0]                 m_wcol;
  logic [YW-1:0]                 m_wrow;
  logic [7:0]                    m_fx;
  logic [7:0]                    m_fy;
  logic [bilup_pkg::COLOR_W-1:0] m_color;
  logic [35:0]                   rsw;
  logic [35:0]                   col_tmp;
  logic                          col_over;

  always_comb begin
    rsw      = 36'(d_side.rowest) * 36'(SRC_WIDTH);
    col_tmp  = 36'(d_side.addr) - rsw;
    col_over = (col_tmp >= 36'(SRC_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_kind  <= d_side.kind;
      m_ok    <= (32'(d_side.addr) < 32'(NPIX));
      m_color <= d_side.color;
      m_xi    <= d_side.cx ? XW'(SRC_WIDTH - 2) : XW'(d_qx >> 8);
      m_yi    <= d_side.cy ? YW'(SRC_HEIGHT - 2) : YW'(d_qy >> 8);
      m_fx    <= d_side.cx ? 8'd0 : d_qx[7:0];
      m_fy    <= d_side.cy ? 8'd0 : d_qy[7:0];
      m_wcol  <= col_over ? XW'(col_tmp - 36'(SRC_WIDTH)) : XW'(col_tmp);
      m_wrow  <= col_over ? YW'(d_side.rowest + 1'b1) : YW'(d_side.rowest);
    end
  end

  // Bank address stage
  logic                          a_valid;
  logic [3:0]                    a_we;
  logic [BA-1:0]                 a_addr [4];
  logic [BA-1:0]                 b_addr_n [4];
  logic [3:0]                    we_n;
  logic [bilup_pkg::COLOR_W-1:0] a_color;
  bilup_pkg::frac_t              a_frac;
  logic                          a_xpar;
  logic                          a_ypar;
  logic                          m_sample;

  assign m_sample = (m_kind == bilup_pkg::KIND_SAMPLE);

  genvar gb;
  for (gb = 0; gb < 4; gb++) begin : g_addr
    logic [XW-1:0] col;
    logic [YW-1:0] row;
    always_comb begin
      if (m_sample) begin
        col = (m_xi[0] == gb[0]) ? m_xi : XW'(m_xi + 1'b1);
        row = (m_yi[0] == gb[1]) ? m_yi : YW'(m_yi + 1'b1);
      end else begin
        col = m_wcol;
        row = m_wrow;
      end
      b_addr_n[gb] = BA'(32'(row >> 1) * 32'(BW) + 32'(col >> 1));
      we_n[gb]     = m_valid && !m_sample && m_ok &&
                     (m_wcol[0] == gb[0]) && (m_wrow[0] == gb[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_we    <= '0;
    end else if (adv) begin
      a_valid <= m_valid && m_sample;
      a_we    <= we_n;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_addr    <= b_addr_n;
      a_color   <= m_color;
      a_frac.fx <= m_fx;
      a_frac.fy <= m_fy;
      a_xpar    <= m_xi[0];
      a_ypar    <= m_yi[0];
    end
  end

  // Banks
  logic [bilup_pkg::COLOR_W-1:0] rd [4];

  for (gb = 0; gb < 4; gb++) begin : g_bank
    bilup_bank #(.DEPTH(BD), .AW(BA)) u_bank (
      .clk  (clk),
      .we   (adv && a_we[gb]),
      .waddr(a_addr[gb]),
      .wdata(a_color),
      .re   (adv && a_valid),
      .raddr(a_addr[gb]),
      .rdata(rd[gb])
    );
  end

  // Read data stage
  logic             b_valid;
  bilup_pkg::frac_t b_frac;
  logic             b_xpar;
  logic             b_ypar;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_frac <= a_frac;
      b_xpar <= a_xpar;
      b_ypar <= a_ypar;
    end
  end

  bilup_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (b_valid),
    .a        (bilup_pkg::rgb_t'(rd[{b_ypar, b_xpar}])),
    .b        (bilup_pkg::rgb_t'(rd[{b_ypar, ~b_xpar}])),
    .c        (bilup_pkg::rgb_t'(rd[{~b_ypar, b_xpar}])),
    .d        (bilup_pkg::rgb_t'(rd[{~b_ypar, ~b_xpar}])),
    .frac     (b_frac),
    .out_valid(out_valid),
    .pixel    (out_pixel)
  );

endmodule
